FILE: rtl/core/wrd_pkg.sv
// Shared types and constants for the wrist raise detector.
package wrd_pkg;

    localparam int FACING_AXIS = 2;
    localparam int AXIS_SEL = FACING_AXIS % 6;
    localparam int AXIS_IDX = AXIS_SEL % 3;
    localparam bit AXIS_NEG = (AXIS_SEL >= 3);

    localparam logic [63:0] NORM_MIN_SQ = 64'd720575940379280;
    localparam logic [12:0] ONE_G_Q12 = 13'd4096;
    localparam logic [14:0] FACING_ONE = 15'd16384;

    localparam logic [2:0] REG_FILTER_GAIN  = 3'd0;
    localparam logic [2:0] REG_ON_COSINE    = 3'd1;
    localparam logic [2:0] REG_OFF_COSINE   = 3'd2;
    localparam logic [2:0] REG_STILL_LIMIT  = 3'd3;
    localparam logic [2:0] REG_MOTION_LIMIT = 3'd4;
    localparam logic [2:0] REG_ON_HOLD      = 3'd5;
    localparam logic [2:0] REG_OFF_HOLD     = 3'd6;
    localparam logic [2:0] REG_SETTLE_HOLD  = 3'd7;

    typedef struct packed {
        logic [15:0]        filter_gain;
        logic signed [15:0] on_cosine;
        logic signed [15:0] off_cosine;
        logic [14:0]        still_limit;
        logic [14:0]        motion_limit;
        logic [9:0]         on_hold;
        logic [9:0]         off_hold;
        logic [9:0]         settle_hold;
    } cfg_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture sample
        logic filt;      // one axis of gravity update (axis in filt_axis)
        logic [1:0] filt_axis;
        logic sq_start;  // begin sum of squares
        logic sq_step;
        logic root_start;
        logic root_step;
        logic div_start;
        logic div_step;
        logic decide;    // update posture state
        logic result;    // load output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic valid_att;
    } stat_t;

endpackage

FILE: rtl/core/wrd_datapath.sv
// Datapath: gravity filter, norm, iterative square root and divider, posture logic.
module wrd_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  wrd_pkg::cfg_t        cfg,
    input  wrd_pkg::cmd_t        cmd,
    output wrd_pkg::stat_t       stat,
    input  logic signed [15:0]   in_x,
    input  logic signed [15:0]   in_y,
    input  logic signed [15:0]   in_z,
    input  logic                 in_last,
    output logic [20:0]          res_data
);

    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic last_reg;
    logic signed [31:0] gx_reg, gy_reg, gz_reg;
    logic seeded_reg, raised_reg, armed_reg, event_reg, valid_reg;
    logic [9:0] on_cnt_reg, off_cnt_reg, settle_cnt_reg;
    logic signed [15:0] facing_reg;
    logic [63:0] gsum_reg;
    logic [33:0] ssum_reg;
    logic [1:0]  sq_idx_reg;
    logic [63:0] rem_reg;
    logic [63:0] root_reg;
    logic [63:0] bit_reg;
    logic [46:0] num_reg;
    logic [32:0] drem_reg;
    logic [15:0] quo_reg;
    logic [5:0]  div_cnt_reg;
    logic [20:0] res_reg;

    // filter of one axis
    logic signed [31:0] g_sel;
    logic signed [15:0] a_sel;
    logic signed [33:0] diff;
    logic signed [50:0] prod;
    logic signed [35:0] stepv;
    logic signed [35:0] rsum;
    logic signed [31:0] g_new;

    always_comb begin
        case (cmd.filt_axis)
            2'd0: begin g_sel = gx_reg; a_sel = ax_reg; end
            2'd1: begin g_sel = gy_reg; a_sel = ay_reg; end
            default: begin g_sel = gz_reg; a_sel = az_reg; end
        endcase
        diff  = {{2{a_sel[15]}}, a_sel, 16'd0} - {{2{g_sel[31]}}, g_sel};
        prod  = diff * $signed({1'b0, cfg.filter_gain});
        stepv = 36'((prod + 51'sd32768) >>> 16);
        rsum  = {{4{g_sel[31]}}, g_sel} + stepv;
        if (!seeded_reg) g_new = {a_sel, 16'd0};
        else if (rsum > 36'sh07FFFFFFF) g_new = 32'h7FFFFFFF;
        else if (rsum < -36'sh080000000) g_new = 32'h80000000;
        else g_new = rsum[31:0];
    end

    // one axis per step: squares of the gravity and sample components
    logic signed [31:0] gq;
    logic signed [15:0] aq;
    logic [31:0] gmag;
    logic [15:0] amag;
    always_comb begin
        case (sq_idx_reg)
            2'd0: begin gq = gx_reg; aq = ax_reg; end
            2'd1: begin gq = gy_reg; aq = ay_reg; end
            default: begin gq = gz_reg; aq = az_reg; end
        endcase
        gmag = gq[31] ? 32'(-gq) : 32'(gq);
        amag = aq[15] ? 16'(-aq) : 16'(aq);
    end

    // square root step
    logic [63:0] trial;
    assign trial = root_reg + bit_reg;

    // facing numerator/divisor
    logic signed [31:0] comp;
    logic comp_neg;
    logic [31:0] comp_mag;
    always_comb begin
        case (2'(wrd_pkg::AXIS_IDX))
            2'd0: comp = gx_reg;
            2'd1: comp = gy_reg;
            default: comp = gz_reg;
        endcase
        comp_neg = comp[31];
        comp_mag = comp_neg ? 32'(-comp) : 32'(comp);
    end

    logic [32:0] dshift;
    assign dshift = {drem_reg[31:0], num_reg[46]};

    // decision
    logic [33:0] s_lo_sq, s_hi_sq, m_lo_sq, m_hi_sq;
    logic signed [16:0] slo, mlo;
    logic [15:0] shi, mhi;
    logic [14:0] q_sat;
    logic signed [15:0] fac;
    logic still, moving, up, down;
    logic [9:0] on_b, off_b, st_b, on_h, off_h, st_h;
    always_comb begin
        slo = 17'sd4096 - $signed({2'b0, cfg.still_limit});
        shi = 16'd4096 + {1'b0, cfg.still_limit};
        mlo = 17'sd4096 - $signed({2'b0, cfg.motion_limit});
        mhi = 16'd4096 + {1'b0, cfg.motion_limit};
        s_lo_sq = slo[16] ? 34'd0 : 34'(slo[15:0] * slo[15:0]);
        s_hi_sq = 34'(shi * shi);
        m_lo_sq = mlo[16] ? 34'd0 : 34'(mlo[15:0] * mlo[15:0]);
        m_hi_sq = 34'(mhi * mhi);
        still  = (slo[16] || ssum_reg > s_lo_sq) && ssum_reg < s_hi_sq;
        moving = ssum_reg > m_hi_sq || (mlo > 0 && ssum_reg < m_lo_sq);
        q_sat = (quo_reg > 16'd16384) ? wrd_pkg::FACING_ONE : quo_reg[14:0];
        fac = ((comp_neg ^ wrd_pkg::AXIS_NEG) ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat}));
        up   = fac >= cfg.on_cosine;
        down = fac <= cfg.off_cosine;
        on_b  = (on_cnt_reg < 10'd1023) ? on_cnt_reg + 10'd1 : on_cnt_reg;
        off_b = (off_cnt_reg < 10'd1023) ? off_cnt_reg + 10'd1 : off_cnt_reg;
        st_b  = (settle_cnt_reg < 10'd1023) ? settle_cnt_reg + 10'd1 : settle_cnt_reg;
        on_h  = cfg.on_hold;
        off_h = cfg.off_hold;
        st_h  = cfg.settle_hold;
    end

    assign stat.valid_att = gsum_reg >= wrd_pkg::NORM_MIN_SQ;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gx_reg <= '0; gy_reg <= '0; gz_reg <= '0;
            seeded_reg <= 1'b0; raised_reg <= 1'b0; armed_reg <= 1'b0;
            on_cnt_reg <= '0; off_cnt_reg <= '0; settle_cnt_reg <= '0;
            facing_reg <= '0; event_reg <= 1'b0; valid_reg <= 1'b0;
            sq_idx_reg <= '0; div_cnt_reg <= '0;
        end else begin
            if (cmd.load) begin
                ax_reg <= in_x; ay_reg <= in_y; az_reg <= in_z; last_reg <= in_last;
                event_reg <= 1'b0; valid_reg <= 1'b0;
            end
            if (cmd.filt) begin
                case (cmd.filt_axis)
                    2'd0: gx_reg <= g_new;
                    2'd1: gy_reg <= g_new;
                    default: begin gz_reg <= g_new; seeded_reg <= 1'b1; end
                endcase
            end
            if (cmd.sq_start) begin
                gsum_reg <= '0; ssum_reg <= '0; sq_idx_reg <= '0;
            end
            if (cmd.sq_step) begin
                gsum_reg <= gsum_reg + 64'(gmag * gmag);
                ssum_reg <= ssum_reg + 34'(amag * amag);
                sq_idx_reg <= sq_idx_reg + 2'd1;
            end
            if (cmd.root_start) begin
                rem_reg <= gsum_reg; root_reg <= '0; bit_reg <= 64'h4000000000000000;
            end
            if (cmd.root_step) begin
                if (rem_reg >= trial) begin
                    rem_reg <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end else begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            if (cmd.div_start) begin
                num_reg <= {1'b0, comp_mag, 14'd0} + {16'd0, root_reg[31:1]};
                drem_reg <= '0; quo_reg <= '0; div_cnt_reg <= '0;
            end
            if (cmd.div_step) begin
                // restoring divide, one quotient bit per cycle over 47 bits
                num_reg <= num_reg << 1;
                div_cnt_reg <= div_cnt_reg + 6'd1;
                if (dshift >= {1'b0, root_reg[31:0]}) begin
                    drem_reg <= dshift - {1'b0, root_reg[31:0]};
                    quo_reg <= (quo_reg << 1) | 16'd1;
                end else begin
                    drem_reg <= dshift;
                    quo_reg <= quo_reg << 1;
                end
            end
            if (cmd.decide && stat.valid_att) begin
                valid_reg <= 1'b1;
                facing_reg <= fac;
                if (!raised_reg) begin
                    if (up) begin
                        if (on_b >= on_h) begin
                            raised_reg <= 1'b1; on_cnt_reg <= '0; off_cnt_reg <= '0;
                        end else on_cnt_reg <= on_b;
                    end else on_cnt_reg <= '0;
                end else begin
                    if (down) begin
                        if (off_b >= off_h) begin
                            raised_reg <= 1'b0; off_cnt_reg <= '0; on_cnt_reg <= '0;
                        end else off_cnt_reg <= off_b;
                    end else off_cnt_reg <= '0;
                end
                if ((armed_reg || moving || down) && up && still) begin
                    if (st_b >= st_h) begin
                        event_reg <= 1'b1; armed_reg <= 1'b0; settle_cnt_reg <= '0;
                    end else begin
                        settle_cnt_reg <= st_b; armed_reg <= 1'b1;
                    end
                end else begin
                    settle_cnt_reg <= '0;
                    if (moving || down) armed_reg <= 1'b1;
                end
            end
            if (cmd.result)
                res_reg <= {last_reg, valid_reg, armed_reg, event_reg, raised_reg, facing_reg};
        end
    end

    assign res_data = res_reg;

    ap_event_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(event_reg) |-> !armed_reg) else $error("event left block armed");
    ap_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        raised_reg |-> on_cnt_reg == 10'd0)
        else $error("on count running while raised");
    ap_event_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.result && event_reg) |-> valid_reg) else $error("event without attitude");

endmodule

FILE: rtl/core/wrd_ctrl.sv
// Controller: sequences filter, squares, root, divide and decision per sample.
module wrd_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  wrd_pkg::stat_t  stat,
    output wrd_pkg::cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_FILT, S_SQ, S_ROOT, S_DIV, S_DECIDE, S_RES
    } state_t;

    state_t state_reg;
    logic [5:0] cnt_reg;
    logic out_valid_reg;

    logic can_res;
    assign can_res = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb begin
        cmd = '0;
        cmd.filt_axis = cnt_reg[1:0];
        case (state_reg)
            S_IDLE: begin
                cmd.load = in_valid;
            end
            S_FILT: begin
                cmd.filt = 1'b1;
                cmd.sq_start = (cnt_reg[1:0] == 2'd2);
            end
            S_SQ: begin
                cmd.sq_step = 1'b1;
            end
            // first cycle loads, the rest step
            S_ROOT: begin
                cmd.root_start = (cnt_reg == 6'd0);
                cmd.root_step = (cnt_reg != 6'd0);
            end
            S_DIV: begin
                cmd.div_start = (cnt_reg == 6'd0);
                cmd.div_step = (cnt_reg != 6'd0);
            end
            S_DECIDE: cmd.decide = 1'b1;
            S_RES: cmd.result = can_res;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (in_valid) begin state_reg <= S_FILT; cnt_reg <= '0; end
                S_FILT: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd2) begin state_reg <= S_SQ; cnt_reg <= '0; end
                end
                S_SQ: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd2) begin state_reg <= S_ROOT; cnt_reg <= '0; end
                end
                S_ROOT: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd32) begin state_reg <= S_DIV; cnt_reg <= '0; end
                end
                S_DIV: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd47) state_reg <= S_DECIDE;
                end
                S_DECIDE: state_reg <= S_RES;
                S_RES: if (can_res) begin
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    ap_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready) |=> out_valid_reg) else $error("result dropped");
    ap_idle_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> state_reg == S_FILT) else $error("accept lost");
    ap_res_path: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg) == S_RES) else $error("stray result");

endmodule

FILE: rtl/core/wrist_raise_detector.sv
// Wrist raise detector: one accelerometer sample in, one posture result out per beat.
// The result is valid once a sample has passed the gravity filter (one axis a cycle through
// one multiplier), the sums of squares, the bit-pair square root of the gravity norm (load
// and 32 steps), the restoring divide that yields facing (load and 47 steps), the decision
// and the load of the output register. The next sample is taken only once the controller is
// back in idle, so samples do not overlap; a result still waiting when the next one is ready
// holds the controller. Writes to the configuration port are taken at any time and should be
// made while idle.
module wrist_raise_detector (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // accel_x, accel_y, accel_z
    input  logic        s_tlast,   // last_in_block
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // facing, raised, raise_event, armed, attitude_valid, pad
    output logic        m_tlast,   // block_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    wrd_pkg::cfg_t  cfg_reg;
    wrd_pkg::cmd_t  cmd;
    wrd_pkg::stat_t stat;
    logic [20:0] res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.filter_gain  <= 16'd1311;
            cfg_reg.on_cosine    <= 16'sd8192;
            cfg_reg.off_cosine   <= 16'sd5571;
            cfg_reg.still_limit  <= 15'd1229;
            cfg_reg.motion_limit <= 15'd1638;
            cfg_reg.on_hold      <= 10'd15;
            cfg_reg.off_hold     <= 10'd40;
            cfg_reg.settle_hold  <= 10'd15;
        end else if (cfg_valid) begin
            case (cfg_index)
                wrd_pkg::REG_FILTER_GAIN:  cfg_reg.filter_gain  <= cfg_data;
                wrd_pkg::REG_ON_COSINE:    cfg_reg.on_cosine    <= cfg_data;
                wrd_pkg::REG_OFF_COSINE:   cfg_reg.off_cosine   <= cfg_data;
                wrd_pkg::REG_STILL_LIMIT:  cfg_reg.still_limit  <= cfg_data[14:0];
                wrd_pkg::REG_MOTION_LIMIT: cfg_reg.motion_limit <= cfg_data[14:0];
                wrd_pkg::REG_ON_HOLD:      cfg_reg.on_hold      <= cfg_data[9:0];
                wrd_pkg::REG_OFF_HOLD:     cfg_reg.off_hold     <= cfg_data[9:0];
                wrd_pkg::REG_SETTLE_HOLD:  cfg_reg.settle_hold  <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    wrd_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .stat(stat), .cmd(cmd)
    );

    wrd_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg), .cmd(cmd), .stat(stat),
        .in_x(s_tdata[15:0]), .in_y(s_tdata[31:16]), .in_z(s_tdata[47:32]),
        .in_last(s_tlast), .res_data(res)
    );

    assign m_tdata = {4'd0, res[19:0]};
    assign m_tlast = res[20];

endmodule
